// File: hw/rtl/assert_macros.svh
// assertion macros shared by the touch trimmed-mean rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/ttmc_pkg.sv
// shared types and constants for the touch trimmed-mean calibrator
// no dependencies; used by every module of the block except ttmc_div
package ttmc_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam int COUNT_W    = 8;
  localparam int SCALE_W    = 20;
  localparam int SHIFT_W    = 16;
  localparam int COORD_W    = 16;
  localparam int DIVR_W     = 14;

  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_X_SCALE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_X_SHIFT      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_SCALE      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_SHIFT      = 3'd4;

  localparam logic [DIVR_W-1:0]  CAL_DIVISOR = 14'd10000;
  localparam logic [COUNT_W-1:0] MIN_COUNT   = 8'd3;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 20'd10000;

  // divide by 10000 as a shift by 4 and a reciprocal multiply for 625,
  // exact for products below 2^36
  localparam int                     CAL_PRE_SHIFT   = 4;
  localparam int                     CAL_RECIP_W     = 33;
  localparam int                     CAL_RECIP_SHIFT = 42;
  localparam logic [CAL_RECIP_W-1:0] CAL_RECIP       = 33'd7036874418;

  localparam int COORD_MAX = 32767;
  localparam int COORD_MIN = -32768;

  typedef struct packed {
    logic [COUNT_W-1:0]        sample_count;
    logic [SCALE_W-1:0]        x_scale;
    logic signed [SHIFT_W-1:0] x_shift;
    logic [SCALE_W-1:0]        y_scale;
    logic signed [SHIFT_W-1:0] y_shift;
  } cal_cfg_t;

  typedef struct packed {
    logic sample;     // accept a sample word into the accumulators
    logic mean_load;  // latch the mean and form scale * mean
    logic cal_start;  // scale the product down by the calibration divisor
    logic emit;       // load the output register
  } dp_cmd_t;

  typedef struct packed {
    logic run_end;    // the sample on the input closes its axis run
    logic div_busy;
    logic div_done;
  } dp_status_t;

endpackage

// File: hw/rtl/touch_trimmed_mean_calibrate.sv
// touch_trimmed_mean_calibrate: trimmed-mean touch filter with linear calibration
// a sample that does not close its axis run gives no word
// a run-closing sample gives its word after the one-bit-per-cycle mean divider, then the
// scale multiply and the reciprocal scale-down by 10000, once the output register is free
// throughput: one sample per cycle within a run; intake pauses while a run result is formed
// reset (rst_n, synchronous, active low) clears config to defaults and both axis accumulators
module touch_trimmed_mean_calibrate #(
  parameter int SAMPLE_BITS = 12,
  parameter int MAX_SAMPLES = 255
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // sample words
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_axis,
  input  logic [SAMPLE_BITS-1:0]                in_sample,
  // result words
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  out_result_axis,
  output logic [SAMPLE_BITS-1:0]                out_raw_mean,
  output logic signed [ttmc_pkg::COORD_W-1:0]   out_display_coord,
  output logic                                  out_clipped,
  // configuration writes
  input  logic                                  cfg_we,
  input  logic [ttmc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ttmc_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  ttmc_pkg::cal_cfg_t   cfg_r;
  ttmc_pkg::cal_cfg_t   cfg_nxt;
  ttmc_pkg::dp_cmd_t    cmd;
  ttmc_pkg::dp_status_t st;

  logic                                out_valid_r;
  logic                                out_valid_nxt;
  logic                                out_axis_r;
  logic [SAMPLE_BITS-1:0]              out_mean_r;
  logic signed [ttmc_pkg::COORD_W-1:0] out_coord_r;
  logic                                out_clip_r;
  logic                                out_busy;

  logic                                res_axis;
  logic [SAMPLE_BITS-1:0]              res_mean;
  logic signed [ttmc_pkg::COORD_W-1:0] res_coord;
  logic                                res_clip;

  // register file; writes past the last register are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        ttmc_pkg::CFG_SAMPLE_COUNT: cfg_nxt.sample_count = cfg_wdata[ttmc_pkg::COUNT_W-1:0];
        ttmc_pkg::CFG_X_SCALE:      cfg_nxt.x_scale      = cfg_wdata[ttmc_pkg::SCALE_W-1:0];
        ttmc_pkg::CFG_X_SHIFT:      cfg_nxt.x_shift      = cfg_wdata[ttmc_pkg::SHIFT_W-1:0];
        ttmc_pkg::CFG_Y_SCALE:      cfg_nxt.y_scale      = cfg_wdata[ttmc_pkg::SCALE_W-1:0];
        ttmc_pkg::CFG_Y_SHIFT:      cfg_nxt.y_shift      = cfg_wdata[ttmc_pkg::SHIFT_W-1:0];
        default:                    cfg_nxt              = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sample_count <= ttmc_pkg::MIN_COUNT;
      cfg_r.x_scale      <= ttmc_pkg::SCALE_RESET;
      cfg_r.x_shift      <= '0;
      cfg_r.y_scale      <= ttmc_pkg::SCALE_RESET;
      cfg_r.y_shift      <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // sequencer drives the datapath through command/status structs
  ttmc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .st       (st),
    .out_busy (out_busy),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  ttmc_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cfg       (cfg_r),
    .in_axis   (in_axis),
    .in_sample (in_sample),
    .status    (st),
    .res_axis  (res_axis),
    .res_mean  (res_mean),
    .res_coord (res_coord),
    .res_clip  (res_clip)
  );

  // output register; a waiting word only holds back the next finished run
  assign out_busy = out_valid_r && !out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_axis_r  <= res_axis;
      out_mean_r  <= res_mean;
      out_coord_r <= res_coord;
      out_clip_r  <= res_clip;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result_axis   = out_axis_r;
  assign out_raw_mean      = out_mean_r;
  assign out_display_coord = out_coord_r;
  assign out_clipped       = out_clip_r;

endmodule

// File: hw/rtl/ttmc_div.sv
// restoring divider, one quotient bit per cycle
// no package dependencies; used by ttmc_datapath
module ttmc_div #(
  parameter int DVD_W = 32,
  parameter int DVR_W = 14
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVR_W-1:0] divisor,
  output logic [DVD_W-1:0] quot,
  output logic             busy,
  output logic             done
);

  localparam int CNT_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVD_W-1:0] quot_r;
  logic [DVR_W-1:0] rem_r;
  logic [DVR_W-1:0] dvr_r;

  logic [DVR_W:0]   rem_sh;
  logic [DVR_W:0]   rem_sub;
  logic             ge;
  logic             last;
  logic [DVD_W-1:0] quot_nxt;
  logic [DVR_W-1:0] rem_nxt;

  always_comb begin
    rem_sh   = {rem_r, quot_r[DVD_W-1]};
    ge       = rem_sh >= {1'b0, dvr_r};
    rem_sub  = rem_sh - {1'b0, dvr_r};
    rem_nxt  = ge ? rem_sub[DVR_W-1:0] : rem_sh[DVR_W-1:0];
    quot_nxt = {quot_r[DVD_W-2:0], ge};
    last     = cnt_r == CNT_W'(DVD_W - 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && last;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (last) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot_r <= dividend;
      rem_r  <= '0;
      dvr_r  <= divisor;
    end else if (busy_r) begin
      quot_r <= quot_nxt;
      rem_r  <= rem_nxt;
    end
  end

  assign quot = quot_r;
  assign busy = busy_r;
  assign done = done_r;

endmodule

// File: hw/rtl/ttmc_datapath.sv
// per-axis accumulators, mean divider, scale multiplier, reciprocal scale-down, saturation
// depends on ttmc_pkg and ttmc_div
module ttmc_datapath #(
  parameter int SAMPLE_BITS = 12,
  parameter int MAX_SAMPLES = 255
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  ttmc_pkg::dp_cmd_t                      cmd,
  input  ttmc_pkg::cal_cfg_t                     cfg,
  input  logic                                   in_axis,
  input  logic [SAMPLE_BITS-1:0]                 in_sample,
  output ttmc_pkg::dp_status_t                   status,
  output logic                                   res_axis,
  output logic [SAMPLE_BITS-1:0]                 res_mean,
  output logic signed [ttmc_pkg::COORD_W-1:0]    res_coord,
  output logic                                   res_clip
);

  localparam int SUM_W  = SAMPLE_BITS + ttmc_pkg::COUNT_W;
  localparam int DIVD_W = ttmc_pkg::SCALE_W + SAMPLE_BITS;
  localparam int PRE_W  = DIVD_W - ttmc_pkg::CAL_PRE_SHIFT;
  localparam int CAL_PROD_W = PRE_W + ttmc_pkg::CAL_RECIP_W;
  localparam logic [ttmc_pkg::COUNT_W-1:0] MAX_CNT = ttmc_pkg::COUNT_W'(MAX_SAMPLES);
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_ALL = {SAMPLE_BITS{1'b1}};
  localparam logic signed [DIVD_W:0] C_MAX = (DIVD_W + 1)'(ttmc_pkg::COORD_MAX);
  localparam logic signed [DIVD_W:0] C_MIN = (DIVD_W + 1)'(ttmc_pkg::COORD_MIN);

  logic [SUM_W-1:0]             sum_r [2];
  logic [SAMPLE_BITS-1:0]       max_r [2];
  logic [SAMPLE_BITS-1:0]       min_r [2];
  logic [ttmc_pkg::COUNT_W-1:0] cnt_r [2];
  logic                         axis_r;
  logic [SAMPLE_BITS-1:0]       mean_r;
  logic [DIVD_W-1:0]            prod_r;
  logic [DIVD_W-1:0]            cal_q_r;

  logic [ttmc_pkg::COUNT_W-1:0] eff_cnt;
  logic [SUM_W-1:0]             sum_nxt;
  logic [SAMPLE_BITS-1:0]       max_nxt;
  logic [SAMPLE_BITS-1:0]       min_nxt;
  logic [ttmc_pkg::COUNT_W-1:0] cnt_nxt;
  logic                         run_end;
  logic [SUM_W-1:0]             trim_sum;

  logic                         div_start;
  logic [DIVD_W-1:0]            div_dvd;
  logic [ttmc_pkg::DIVR_W-1:0]  div_dvr;
  logic [DIVD_W-1:0]            quot;
  logic                         div_busy;
  logic                         div_done;

  logic [ttmc_pkg::SCALE_W-1:0]        scale_sel;
  logic signed [ttmc_pkg::SHIFT_W-1:0] shift_sel;
  logic [CAL_PROD_W-1:0]               cal_prod;
  logic signed [DIVD_W:0]              coord_full;

  // running statistics for the axis on the input
  always_comb begin
    if (cfg.sample_count < ttmc_pkg::MIN_COUNT) begin
      eff_cnt = ttmc_pkg::MIN_COUNT;
    end else if (cfg.sample_count > MAX_CNT) begin
      eff_cnt = MAX_CNT;
    end else begin
      eff_cnt = cfg.sample_count;
    end
    sum_nxt  = sum_r[in_axis] + SUM_W'(in_sample);
    max_nxt  = (in_sample > max_r[in_axis]) ? in_sample : max_r[in_axis];
    min_nxt  = (in_sample < min_r[in_axis]) ? in_sample : min_r[in_axis];
    cnt_nxt  = cnt_r[in_axis] + 1'b1;
    run_end  = cnt_nxt >= eff_cnt;
    trim_sum = sum_nxt - SUM_W'(max_nxt) - SUM_W'(min_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 2; i++) begin
        sum_r[i] <= '0;
        max_r[i] <= '0;
        min_r[i] <= SAMPLE_ALL;
        cnt_r[i] <= '0;
      end
    end else if (cmd.sample) begin
      if (run_end) begin
        sum_r[in_axis] <= '0;
        max_r[in_axis] <= '0;
        min_r[in_axis] <= SAMPLE_ALL;
        cnt_r[in_axis] <= '0;
      end else begin
        sum_r[in_axis] <= sum_nxt;
        max_r[in_axis] <= max_nxt;
        min_r[in_axis] <= min_nxt;
        cnt_r[in_axis] <= cnt_nxt;
      end
    end
  end

  // divider forms the trimmed mean at the end of a run
  always_comb begin
    div_start = cmd.sample && run_end;
    div_dvd   = DIVD_W'(trim_sum);
    div_dvr   = ttmc_pkg::DIVR_W'(cnt_nxt - ttmc_pkg::COUNT_W'(2));
  end

  ttmc_div #(
    .DVD_W (DIVD_W),
    .DVR_W (ttmc_pkg::DIVR_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvr),
    .quot     (quot),
    .busy     (div_busy),
    .done     (div_done)
  );

  assign scale_sel = axis_r ? cfg.y_scale : cfg.x_scale;
  assign shift_sel = axis_r ? cfg.y_shift : cfg.x_shift;

  // floor(prod / 10000): drop four bits, then multiply by the reciprocal of 625
  assign cal_prod = CAL_PROD_W'(prod_r[DIVD_W-1:ttmc_pkg::CAL_PRE_SHIFT]) *
                    CAL_PROD_W'(ttmc_pkg::CAL_RECIP);

  always_ff @(posedge clk) begin
    if (cmd.sample && run_end) begin
      axis_r <= in_axis;
    end
    if (cmd.mean_load) begin
      mean_r <= quot[SAMPLE_BITS-1:0];
      prod_r <= DIVD_W'(scale_sel) * DIVD_W'(quot[SAMPLE_BITS-1:0]);
    end
    if (cmd.cal_start) begin
      cal_q_r <= DIVD_W'(cal_prod >> ttmc_pkg::CAL_RECIP_SHIFT);
    end
  end

  // offset and saturate the scaled mean
  always_comb begin
    coord_full = $signed({1'b0, cal_q_r}) +
                 $signed({{(DIVD_W + 1 - ttmc_pkg::SHIFT_W){shift_sel[ttmc_pkg::SHIFT_W-1]}},
                          shift_sel});
    res_clip = 1'b0;
    if (coord_full > C_MAX) begin
      res_coord = ttmc_pkg::COORD_W'(ttmc_pkg::COORD_MAX);
      res_clip  = 1'b1;
    end else if (coord_full < C_MIN) begin
      res_coord = ttmc_pkg::COORD_W'(ttmc_pkg::COORD_MIN);
      res_clip  = 1'b1;
    end else begin
      res_coord = coord_full[ttmc_pkg::COORD_W-1:0];
    end
  end

  assign res_axis = axis_r;
  assign res_mean = mean_r;

  assign status.run_end  = run_end;
  assign status.div_busy = div_busy;
  assign status.div_done = div_done;

endmodule

// File: hw/rtl/ttmc_ctrl.sv
// sequencer: sample intake, mean divide, scale, calibration scale-down, output
// depends on ttmc_pkg and assert_macros.svh
`include "assert_macros.svh"

module ttmc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  ttmc_pkg::dp_status_t st,
  input  logic                 out_busy,
  output logic                 in_ready,
  output ttmc_pkg::dp_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MEAN   = 3'd1;
  localparam logic [2:0] S_CAL_GO = 3'd2;
  localparam logic [2:0] S_OUT    = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.sample = in_valid;
        if (in_valid && st.run_end) begin
          state_nxt = S_MEAN;
        end
      end
      S_MEAN: begin
        if (st.div_done) begin
          cmd.mean_load = 1'b1;
          state_nxt     = S_CAL_GO;
        end
      end
      S_CAL_GO: begin
        cmd.cal_start = 1'b1;
        state_nxt     = S_OUT;
      end
      S_OUT: begin
        if (!out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `ASSERT_IMPL(a_idle_div_free, clk, rst_n, state_r == S_IDLE, !st.div_busy, "divider busy while idle")
  `ASSERT_NEXT(a_run_end_starts_div, clk, rst_n, cmd.sample && st.run_end, st.div_busy, "mean divide not started")
  `ASSERT_IMPL(a_cal_go_clear, clk, rst_n, state_r == S_CAL_GO, !st.div_busy && !st.div_done, "divider not free for calibration")
  `ASSERT_IMPL(a_done_after_busy, clk, rst_n, st.div_done, $past(st.div_busy), "divide done without work")

endmodule

// File: tb/ttmc_checker.sv
// ttmc_checker: watches the sample, result and register ports of the touch trimmed-mean
// calibrator, predicts each finished reading and compares it with the result words
// depends on ttmc_pkg for register indexes, widths and calibration constants
`timescale 1ns / 100ps

module ttmc_checker #(
  parameter int SAMPLE_BITS = 12,
  parameter int MAX_SAMPLES = 255
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic                                in_axis,
  input  logic [SAMPLE_BITS-1:0]              in_sample,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic                                out_result_axis,
  input  logic [SAMPLE_BITS-1:0]              out_raw_mean,
  input  logic signed [ttmc_pkg::COORD_W-1:0] out_display_coord,
  input  logic                                out_clipped,
  input  logic                                cfg_we,
  input  logic [ttmc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ttmc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output int                                  readings_owed,
  output int                                  mismatch_count
);
  import ttmc_pkg::*;

  localparam int SUM_W = SAMPLE_BITS + COUNT_W;

  typedef struct packed {
    logic                      axis;
    logic [SAMPLE_BITS-1:0]    mean;
    logic signed [COORD_W-1:0] coord;
    logic                      clip;
  } reading_t;

  reading_t               owed_readings[$];
  cal_cfg_t               cal;
  logic [SUM_W-1:0]       run_sum [2];
  logic [SAMPLE_BITS-1:0] run_max [2];
  logic [SAMPLE_BITS-1:0] run_min [2];
  logic [COUNT_W-1:0]     run_len [2];
  int                     fails = 0;

  function automatic void clear_run(input logic ax);
    run_sum[ax] = '0;
    run_max[ax] = '0;
    run_min[ax] = '1;
    run_len[ax] = '0;
  endfunction

  // adds one sample to its axis run and, when the run closes, queues the reading
  function automatic void accumulate_sample(input logic ax, input logic [SAMPLE_BITS-1:0] s);
    logic [COUNT_W-1:0]        need;
    logic [SCALE_W-1:0]        scale;
    logic signed [SHIFT_W-1:0] shift;
    longint unsigned           mean;
    longint unsigned           scaled;
    longint                    coord;
    reading_t                  r;
    run_sum[ax] = run_sum[ax] + s;
    if (s > run_max[ax]) run_max[ax] = s;
    if (s < run_min[ax]) run_min[ax] = s;
    run_len[ax] = run_len[ax] + 1'b1;
    need = cal.sample_count;
    if (need < MIN_COUNT) need = MIN_COUNT;
    if (int'(need) > MAX_SAMPLES) need = COUNT_W'(MAX_SAMPLES);
    // a run already past a lowered count closes here too
    if (run_len[ax] < need) return;
    mean = (64'(run_sum[ax]) - 64'(run_max[ax]) - 64'(run_min[ax])) /
           (64'(run_len[ax]) - 64'd2);
    scale  = ax ? cal.y_scale : cal.x_scale;
    shift  = ax ? cal.y_shift : cal.x_shift;
    scaled = 64'(scale) * mean / 64'(CAL_DIVISOR);
    coord  = longint'(scaled) + longint'(shift);
    r.clip = 1'b0;
    if (coord > COORD_MAX) begin
      coord  = COORD_MAX;
      r.clip = 1'b1;
    end else if (coord < COORD_MIN) begin
      coord  = COORD_MIN;
      r.clip = 1'b1;
    end
    r.axis  = ax;
    r.mean  = mean[SAMPLE_BITS-1:0];
    r.coord = coord[COORD_W-1:0];
    owed_readings.push_back(r);
    clear_run(ax);
  endfunction

  always @(posedge clk) begin : watch
    reading_t want;
    if (!rst_n) begin
      cal.sample_count = MIN_COUNT;
      cal.x_scale      = SCALE_RESET;
      cal.x_shift      = '0;
      cal.y_scale      = SCALE_RESET;
      cal.y_shift      = '0;
      clear_run(1'b0);
      clear_run(1'b1);
      owed_readings.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (owed_readings.size() == 0) begin
          $error("result word with no reading owed: axis %0d mean %0d coord %0d",
                 out_result_axis, out_raw_mean, out_display_coord);
          fails++;
        end else begin
          want = owed_readings.pop_front();
          if (out_result_axis !== want.axis) begin
            $error("result_axis: expected %0d, actual %0d", want.axis, out_result_axis);
            fails++;
          end
          if (out_raw_mean !== want.mean) begin
            $error("raw_mean: expected %0d, actual %0d", want.mean, out_raw_mean);
            fails++;
          end
          if (out_display_coord !== want.coord) begin
            $error("display_coord: expected %0d, actual %0d", want.coord, out_display_coord);
            fails++;
          end
          if (out_clipped !== want.clip) begin
            $error("clipped: expected %0d, actual %0d", want.clip, out_clipped);
            fails++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_SAMPLE_COUNT: cal.sample_count = cfg_wdata[COUNT_W-1:0];
          CFG_X_SCALE:      cal.x_scale      = cfg_wdata[SCALE_W-1:0];
          CFG_X_SHIFT:      cal.x_shift      = cfg_wdata[SHIFT_W-1:0];
          CFG_Y_SCALE:      cal.y_scale      = cfg_wdata[SCALE_W-1:0];
          CFG_Y_SHIFT:      cal.y_shift      = cfg_wdata[SHIFT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) accumulate_sample(in_axis, in_sample);
    end
    readings_owed  <= owed_readings.size();
    mismatch_count <= fails;
  end

endmodule

// File: tb/touch_trimmed_mean_calibrate_tb.sv
// touch_trimmed_mean_calibrate_tb: drives sample words and register writes into the
// touch trimmed-mean calibrator, idles both channels at random and gives the verdict
// depends on ttmc_pkg, the block and ttmc_checker, which does all prediction and checking
`timescale 1ns / 100ps

module touch_trimmed_mean_calibrate_tb;
  import ttmc_pkg::*;

  localparam int SAMPLE_BITS    = 12;
  localparam int MAX_SAMPLES    = 255;
  // a pause that covers any tail of work a run-closing sample leaves at these sizes
  localparam int SETTLE_CYCLES  = 100;
  // longest legal quiet stretch is a settle pause plus writes plus a gap, well under this
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES  = 10;
  localparam int PHASE_WORDS    = 40;
  // one phase runs at the largest count, on a single axis, to keep it short
  localparam int LONG_RUN_PHASE = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = CFG_Y_SHIFT + 1'b1;

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_ready;
  logic                         in_axis;
  logic [SAMPLE_BITS-1:0]       in_sample;
  logic                         out_valid;
  logic                         out_ready;
  logic                         out_result_axis;
  logic [SAMPLE_BITS-1:0]       out_raw_mean;
  logic signed [COORD_W-1:0]    out_display_coord;
  logic                         out_clipped;
  logic                         cfg_we;
  logic [CFG_IDX_W-1:0]         cfg_index;
  logic [CFG_DATA_W-1:0]        cfg_wdata;
  int                           readings_owed;
  int                           mismatch_count;
  int                           quiet_cycles = 0;

  // phases where a side never idles
  bit                           feed_steady  = 1'b0;
  bit                           drain_steady = 1'b0;
  // per-axis center of a simulated touch, samples cluster just above it
  logic [SAMPLE_BITS-1:0]       touch_base [2];

  always #1 clk = ~clk;

  touch_trimmed_mean_calibrate #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .MAX_SAMPLES(MAX_SAMPLES)
  ) DUT (.*);

  ttmc_checker #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .MAX_SAMPLES(MAX_SAMPLES)
  ) reading_check (.*);

  // offers one sample word after a random gap and holds it until taken
  task automatic send_sample(input logic ax, input logic [SAMPLE_BITS-1:0] s);
    int gap;
    gap = feed_steady ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_axis   <= ax;
    in_sample <= s;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  // stops sending, waits for every owed reading, then lets any trailing work finish
  task automatic wait_until_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (readings_owed != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // writes all five registers plus one unused index, only once the block is idle
  task automatic apply_settings(input logic [COUNT_W-1:0] count,
                                input logic [SCALE_W-1:0] xs,
                                input logic signed [SHIFT_W-1:0] xsh,
                                input logic [SCALE_W-1:0] ys,
                                input logic signed [SHIFT_W-1:0] ysh);
    wait_until_idle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SAMPLE_COUNT;
    cfg_wdata <= CFG_DATA_W'(count);
    @(posedge clk);
    cfg_index <= CFG_X_SCALE;
    cfg_wdata <= xs;
    @(posedge clk);
    // shifts go out sign-extended so the upper data bits toggle too
    cfg_index <= CFG_X_SHIFT;
    cfg_wdata <= CFG_DATA_W'(xsh);
    @(posedge clk);
    cfg_index <= CFG_Y_SCALE;
    cfg_wdata <= ys;
    @(posedge clk);
    cfg_index <= CFG_Y_SHIFT;
    cfg_wdata <= CFG_DATA_W'(ysh);
    @(posedge clk);
    // an index past the last register must leave everything alone
    cfg_index <= CFG_FIRST_UNUSED + CFG_IDX_W'($urandom_range(0, 2));
    cfg_wdata <= CFG_DATA_W'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // mix of rail values, clustered touch readings and full-range noise
  function automatic logic [SAMPLE_BITS-1:0] pick_sample(input logic ax);
    int kind;
    kind = $urandom_range(0, 9);
    case (kind)
      0:          return '0;
      1:          return '1;
      2, 3, 4, 5: return touch_base[ax] + SAMPLE_BITS'($urandom_range(0, 63));
      default:    return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // zero, unity, all ones, or a spread that often stays below saturation
  function automatic logic [SCALE_W-1:0] pick_scale();
    case ($urandom_range(0, 6))
      0:       return '0;
      1:       return SCALE_RESET;
      2:       return '1;
      3, 4:    return SCALE_W'($urandom_range(0, 20000));
      default: return SCALE_W'($urandom_range(0, 1000000));
    endcase
  endfunction

  function automatic logic signed [SHIFT_W-1:0] pick_shift();
    case ($urandom_range(0, 5))
      0:       return SHIFT_W'(COORD_MIN);
      1:       return SHIFT_W'(COORD_MAX);
      2:       return '0;
      default: return SHIFT_W'($urandom);
    endcase
  endfunction

  // result side: random stall before each word, ready held until it is taken
  initial begin : result_sink
    int stall;
    out_ready = 1'b0;
    forever begin
      stall = drain_steady ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // ends the run when neither channel moves a word for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int                 words;
    logic [COUNT_W-1:0] count;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_axis       = 1'b0;
    in_sample     = '0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    touch_base[0] = '0;
    touch_base[1] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: three samples, unity scale, no shift
    // interleaved axes, full-scale x and zero y
    send_sample(1'b0, '1);
    send_sample(1'b1, '0);
    send_sample(1'b0, '1);
    send_sample(1'b1, '0);
    send_sample(1'b0, '1);
    send_sample(1'b1, '0);
    // both rails get trimmed, the middle value survives
    send_sample(1'b0, '0);
    send_sample(1'b0, '1);
    send_sample(1'b0, SAMPLE_BITS'(2048));
    // alternating bit patterns
    send_sample(1'b1, SAMPLE_BITS'(12'hAAA));
    send_sample(1'b1, SAMPLE_BITS'(12'h555));
    send_sample(1'b1, '1);

    // count of zero acts as three; largest x scale saturates high,
    // zero y scale leaves just the most negative shift, which is not clipped
    apply_settings(8'd0, '1, SHIFT_W'(COORD_MAX), '0, SHIFT_W'(COORD_MIN));
    send_sample(1'b0, '1);
    send_sample(1'b0, '1);
    send_sample(1'b0, '1);
    send_sample(1'b1, SAMPLE_BITS'(1));
    send_sample(1'b1, SAMPLE_BITS'(2));
    send_sample(1'b1, SAMPLE_BITS'(3));

    // start an x run of five, leave it three samples in
    apply_settings(8'd5, 20'd1000000, SHIFT_W'(COORD_MIN), SCALE_RESET, 16'sd12345);
    send_sample(1'b0, SAMPLE_BITS'(10));
    send_sample(1'b0, SAMPLE_BITS'(20));
    send_sample(1'b0, SAMPLE_BITS'(30));

    // count lowered below the run length: next x sample closes a four-sample run;
    // count of two acts as three on y
    apply_settings(8'd2, 20'd1000000, SHIFT_W'(COORD_MIN), SCALE_RESET, 16'sd12345);
    send_sample(1'b0, SAMPLE_BITS'(40));
    send_sample(1'b1, SAMPLE_BITS'(7));
    send_sample(1'b1, SAMPLE_BITS'(8));
    send_sample(1'b1, SAMPLE_BITS'(9));

    // random phases; partial runs carry across settings on purpose
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == LONG_RUN_PHASE) count = COUNT_W'(MAX_SAMPLES);
      else if ($urandom_range(0, 4) == 0) count = COUNT_W'($urandom_range(0, 2));
      else count = COUNT_W'($urandom_range(3, 8));
      apply_settings(count, pick_scale(), pick_shift(), pick_scale(), pick_shift());
      feed_steady   = ($urandom_range(0, 3) == 0);
      drain_steady  = ($urandom_range(0, 3) == 0);
      touch_base[0] = SAMPLE_BITS'($urandom_range(0, 4095 - 63));
      touch_base[1] = SAMPLE_BITS'($urandom_range(0, 4095 - 63));
      words = (p == LONG_RUN_PHASE) ? MAX_SAMPLES : PHASE_WORDS;
      for (int i = 0; i < words; i++) begin
        if (p == LONG_RUN_PHASE) send_sample(1'b0, pick_sample(1'b0));
        else begin
          in_axis_pick : begin
            logic ax;
            ax = 1'($urandom_range(0, 1));
            send_sample(ax, pick_sample(ax));
          end
        end
      end
    end

    wait_until_idle();
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
